// File: design/uer_pkg.sv
// Shared types and constants for the ultrasonic echo ranger.
package uer_pkg;

  localparam int COUNT_WIDTH = 10;   // sample counter width
  localparam int TICK_WIDTH  = 10;   // tick counter width
  localparam int CFG_DATA_W  = 10;
  localparam int CFG_IDX_W   = 2;

  localparam logic [TICK_WIDTH-1:0] REV_SHORT_LEN = TICK_WIDTH'(2);
  localparam logic [TICK_WIDTH-1:0] REV_PULSE_LEN = TICK_WIDTH'(10);
  localparam logic [TICK_WIDTH-1:0] FWD_FIRST_LEN = TICK_WIDTH'(500);
  localparam logic [TICK_WIDTH-1:0] FWD_OTHER_LEN = TICK_WIDTH'(200);

  localparam logic [9:0] RESET_PERIOD = 10'd50;
  localparam logic [9:0] RESET_LIMIT  = 10'd300;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_TRIG1 = 3'd1,
    PH_TRIG2 = 3'd2,
    PH_TRIG3 = 3'd3,
    PH_WAIT  = 3'd4,
    PH_COUNT = 3'd5
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REVERSE_MODE  = 2'd0,
    REG_SAMPLE_PERIOD = 2'd1,
    REG_COUNT_LIMIT   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic       reverse_mode;
    logic [9:0] sample_period;
    logic [9:0] count_limit;
  } cfg_t;

  typedef struct packed {
    logic       trigger_level;
    logic       busy_res;
    logic       done_res;
    logic [9:0] echo_count;
    logic       valid_res;
  } result_t;

endpackage

// File: design/uer_ifs.sv
// Handshake channel interfaces: tick input, result output, register write.
interface uer_tick_if;
  logic valid;
  logic ready;
  logic start_req;
  logic echo;

  modport source (output valid, output start_req, output echo, input ready);
  modport sink   (input valid, input start_req, input echo, output ready);
endinterface

interface uer_result_if;
  logic       valid;
  logic       ready;
  logic       trigger_level;
  logic       busy_res;
  logic       done_res;
  logic [9:0] echo_count;
  logic       valid_res;

  modport source (output valid, output trigger_level, output busy_res, output done_res,
                  output echo_count, output valid_res, input ready);
  modport sink   (input valid, input trigger_level, input busy_res, input done_res,
                  input echo_count, input valid_res, output ready);
endinterface

interface uer_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [9:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// File: design/ultrasonic_echo_ranger.sv
// Top level of the ultrasonic echo ranger: register port, core and result register.
//
// Ultrasonic echo ranger. Each item on the tick channel is one microsecond
// time-base tick carrying a start request and the sampled echo level; every
// tick produces exactly one result item with the trigger line level, busy,
// a one-tick done flag, the echo sample count and a valid flag. A start in
// idle launches a three-phase trigger pulse (reverse mode: low 2, high 10,
// low 2 ticks; otherwise high 500, low 200, high 200), then the block waits
// for the echo to go active (high in reverse mode, low otherwise) and counts
// one sample every sample_period ticks until the echo drops (valid) or the
// count reaches count_limit or counter full (invalid). Starts while busy are
// dropped. Rate: one tick per clock cycle while the result channel is ready;
// a result appears in the cycle after its tick is taken, set by the single
// result register behind the state update. The tick channel stays ready
// while that register is empty or being drained, so back-pressure on the
// result channel holds the tick channel for exactly as long. Registers (index:
// 0 reverse_mode, 1 sample_period, 2 count_limit) are written on a clock edge,
// always ready; write them only while no item is in flight. A change made
// during a measurement takes effect from the next tick. Other indexes are ignored.
module ultrasonic_echo_ranger (
  input  logic         clk,
  input  logic         rst,
  uer_tick_if.sink     tick,
  uer_result_if.source result,
  uer_cfg_if.sink      cfg
);
  import uer_pkg::*;

  cfg_t    cfg_regs;
  result_t step_res;
  result_t res_data;
  logic    res_valid;
  logic    step;

  // Register write port: always ready.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.reverse_mode  <= 1'b1;
      cfg_regs.sample_period <= RESET_PERIOD;
      cfg_regs.count_limit   <= RESET_LIMIT;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_REVERSE_MODE:  cfg_regs.reverse_mode  <= cfg.data[0];
        REG_SAMPLE_PERIOD: cfg_regs.sample_period <= cfg.data;
        REG_COUNT_LIMIT:   cfg_regs.count_limit   <= cfg.data;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Take a tick whenever the result register is free or drains this cycle.
  assign tick.ready = !res_valid || result.ready;
  assign step       = tick.valid && tick.ready;

  uer_core u_core (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .start_req (tick.start_req),
    .echo      (tick.echo),
    .cfg       (cfg_regs),
    .res       (step_res)
  );

  // Result register: advance on a new tick, hold under back-pressure.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (step) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      res_data <= step_res;
    end
  end

  assign result.valid         = res_valid;
  assign result.trigger_level = res_data.trigger_level;
  assign result.busy_res      = res_data.busy_res;
  assign result.done_res      = res_data.done_res;
  assign result.echo_count    = res_data.echo_count;
  assign result.valid_res     = res_data.valid_res;

`ifndef ASSERT_OFF
  a_tick_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> res_valid)
    else $error("accepted tick left no result");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |-> !step)
    else $error("pending result overwritten");
  a_cfg_reset: assert property (@(posedge clk)
    $past(rst) |-> cfg_regs.reverse_mode && cfg_regs.sample_period == RESET_PERIOD)
    else $error("registers not at reset values after reset");
`endif

endmodule

// File: design/uer_core.sv
// Measurement state machine: trigger phases, echo wait and sample counting.
module uer_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  logic            start_req,
  input  logic            echo,
  input  uer_pkg::cfg_t   cfg,
  output uer_pkg::result_t res
);
  import uer_pkg::*;

  phase_t                  phase, phase_next;
  logic [TICK_WIDTH-1:0]   tick_counter, tick_counter_next;
  logic [COUNT_WIDTH-1:0]  sample_counter, sample_counter_next;
  logic                    trigger_reg, trigger_reg_next;

  logic                    active;
  logic [TICK_WIDTH-1:0]   cur_len;
  logic [COUNT_WIDTH-1:0]  sample_inc;
  logic                    over_limit;
  logic                    done, valid;

  function automatic logic level_of(input phase_t ph, input logic rev);
    return rev ? (ph == PH_TRIG2) : (ph != PH_TRIG2);
  endfunction

  assign active = cfg.reverse_mode ? echo : ~echo;

  always_comb begin
    if (cfg.reverse_mode) begin
      cur_len = (phase == PH_TRIG2) ? REV_PULSE_LEN : REV_SHORT_LEN;
    end else begin
      cur_len = (phase == PH_TRIG1) ? FWD_FIRST_LEN : FWD_OTHER_LEN;
    end
  end

  assign sample_inc = sample_counter + COUNT_WIDTH'(1);
  assign over_limit = (COUNT_WIDTH'(cfg.count_limit) <= sample_inc) ||
                      (sample_inc == {COUNT_WIDTH{1'b1}});

  always_comb begin
    phase_next          = phase;
    tick_counter_next   = tick_counter;
    sample_counter_next = sample_counter;
    trigger_reg_next    = trigger_reg;
    done                = 1'b0;
    valid               = 1'b0;
    unique case (phase)
      PH_IDLE: begin
        if (start_req) begin
          phase_next        = PH_TRIG1;
          tick_counter_next = TICK_WIDTH'(1);
          trigger_reg_next  = level_of(PH_TRIG1, cfg.reverse_mode);
        end
      end
      PH_TRIG1, PH_TRIG2, PH_TRIG3: begin
        if (tick_counter >= cur_len) begin
          if (phase == PH_TRIG3) begin
            phase_next        = PH_WAIT;
            tick_counter_next = '0;
          end else begin
            phase_next        = phase_t'(phase + 3'd1);
            tick_counter_next = TICK_WIDTH'(1);
            trigger_reg_next  = level_of(phase_t'(phase + 3'd1), cfg.reverse_mode);
          end
        end else begin
          tick_counter_next = tick_counter + TICK_WIDTH'(1);
        end
      end
      PH_WAIT: begin
        if (active) begin
          phase_next          = PH_COUNT;
          tick_counter_next   = '0;
          sample_counter_next = '0;
        end
      end
      PH_COUNT: begin
        if (tick_counter == '0) begin
          sample_counter_next = sample_inc;
          if (over_limit) begin
            done = 1'b1;
          end else if (!active) begin
            done  = 1'b1;
            valid = 1'b1;
          end
          if (done) begin
            phase_next = PH_IDLE;
          end else if (cfg.sample_period == '0) begin
            tick_counter_next = '0;
          end else begin
            tick_counter_next = TICK_WIDTH'(cfg.sample_period - 10'd1);
          end
        end else begin
          tick_counter_next = tick_counter - TICK_WIDTH'(1);
        end
      end
      default: begin
        phase_next        = PH_IDLE;
        tick_counter_next = '0;
      end
    endcase
  end

  always_comb begin
    res.trigger_level = trigger_reg_next;
    res.busy_res      = (phase_next != PH_IDLE);
    res.done_res      = done;
    res.echo_count    = done ? 10'(sample_inc) : 10'd0;
    res.valid_res     = valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      tick_counter   <= '0;
      sample_counter <= '0;
      trigger_reg    <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      tick_counter   <= tick_counter_next;
      sample_counter <= sample_counter_next;
      trigger_reg    <= trigger_reg_next;
    end
  end

`ifndef ASSERT_OFF
  a_hold_without_step: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable(phase) && $stable(tick_counter) && $stable(sample_counter))
    else $error("state moved without an accepted item");
  a_wait_exit: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_WAIT |=> phase == PH_WAIT || phase == PH_COUNT)
    else $error("wait phase left for a phase other than count");
  a_done_only_counting: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> phase == PH_COUNT && tick_counter == '0)
    else $error("done outside a sample tick");
  a_valid_needs_done: assert property (@(posedge clk) disable iff (rst)
    res.valid_res || res.echo_count != 10'd0 |-> res.done_res && !res.busy_res)
    else $error("valid or count shown without done");
`endif

endmodule
